// File: design/ter_pkg.sv
// ============================================================================
// ter_pkg - shared types and constants for the timed event replay block
// Holds field widths, action codes, the sequencer state type and the
// per-cell control group.
// ============================================================================
package ter_pkg;

    // default configuration
    localparam int MAX_EVENTS_DEF = 64;
    localparam int KEY_COUNT_DEF  = 64;
    localparam int TIME_BITS_DEF  = 32;

    // stream field widths
    localparam int IN_TIME_W   = 32;
    localparam int ACTION_W    = 2;
    localparam int KEY_W       = 6;
    localparam int KEYMAP_W    = 64;
    localparam int FIRED_W     = 7;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 80;
    localparam int OUT_PAD_W   = OUT_DATA_W - KEYMAP_W - 1 - FIRED_W - 1;
    localparam int TIME_EXT_W  = 64;

    localparam logic [FIRED_W-1:0] FIRED_MAX = '1;

    // input selector codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PRESS      = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DISCONNECT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FIRE,
        ST_RESULT
    } t_state;

    // control group broadcast to every cell of the table
    typedef struct packed {
        logic load;   // insert the new entry at the marked slot
        logic pop;    // drop the head entry, shift the row toward the head
    } t_cell_ctl;

endpackage

// File: design/ter_cell.sv
// ============================================================================
// ter_cell - one slot of the sorted event table
// Holds one entry; on insert takes the new entry or its left neighbor, on
// pop takes its right neighbor.
// ============================================================================
module ter_cell
    import ter_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int CNT_W     = 7,
    parameter int INDEX     = 0
) (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [TIME_BITS-1:0] i_new_time,
    input  logic [ACTION_W-1:0]  i_new_action,
    input  logic [KEY_W-1:0]     i_new_key,
    input  logic                 i_left_mark,
    input  logic [TIME_BITS-1:0] i_left_time,
    input  logic [ACTION_W-1:0]  i_left_action,
    input  logic [KEY_W-1:0]     i_left_key,
    input  logic [TIME_BITS-1:0] i_right_time,
    input  logic [ACTION_W-1:0]  i_right_action,
    input  logic [KEY_W-1:0]     i_right_key,
    output logic                 o_mark,
    output logic [TIME_BITS-1:0] o_time,
    output logic [ACTION_W-1:0]  o_action,
    output logic [KEY_W-1:0]     o_key
);

    logic [TIME_BITS-1:0] r_time,   n_time;
    logic [ACTION_W-1:0]  r_action, n_action;
    logic [KEY_W-1:0]     r_key,    n_key;
    logic                 w_occupied;

    // mark: this slot lies between the insert point and the fill level
    assign w_occupied = i_count > CNT_W'(INDEX);
    assign o_mark     = w_occupied ? (r_time > i_new_time)
                                   : (i_count == CNT_W'(INDEX));

    always_comb begin
        n_time   = r_time;
        n_action = r_action;
        n_key    = r_key;
        if (i_ctl.load && o_mark) begin
            if (i_left_mark) begin
                n_time   = i_left_time;
                n_action = i_left_action;
                n_key    = i_left_key;
            end else begin
                n_time   = i_new_time;
                n_action = i_new_action;
                n_key    = i_new_key;
            end
        end else if (i_ctl.pop) begin
            n_time   = i_right_time;
            n_action = i_right_action;
            n_key    = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time   <= n_time;
        r_action <= n_action;
        r_key    <= n_key;
    end

    assign o_time   = r_time;
    assign o_action = r_action;
    assign o_key    = r_key;

endmodule

// File: design/timed_event_replay.sv
// ============================================================================
// timed_event_replay - time-sorted table of key actions replayed by tick
// Loads timed press, release and disconnect entries into a sorted row of
// cells and fires the entries due on each tick, returning the key bitmap.
// ============================================================================
// Every input transaction yields exactly one result transaction. A load
// (tuser = 0) is captured on acceptance; in ST_LOAD every cell of the row
// compares its time with the new entry and the row opens a slot by moving
// each later entry one cell to the right, and in ST_RESULT the result is
// written to the output register. A tick (tuser = 1) fires entries in
// ST_FIRE: the head of the table always sits in cell 0, and one entry
// leaves it per cycle while the row shifts toward the head, so the number
// fired is bounded by MAX_EVENTS. A finished result waits in the output
// register while the next transaction is accepted; the block then holds
// the new result until the register drains. Loads are refused once the
// table is full or after the first tick. The key bitmap and finished flag
// are cleared by reset; the table contents are not, and only slots below
// the fill count are ever read.
// ============================================================================
module timed_event_replay
    import ter_pkg::*;
#(
    parameter int MAX_EVENTS = MAX_EVENTS_DEF,
    parameter int KEY_COUNT  = KEY_COUNT_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] entry_time, [33:32] entry_action, [39:34] entry_key,
    // [71:40] now_tick
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [63:0] keys_pressed, [64] finished, [71:65] fired_count,
    // [72] load_rejected, [79:73] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(MAX_EVENTS + 1);

    // sequencer
    t_state r_state, n_state;

    // captured item
    logic [TIME_BITS-1:0] r_time;
    logic [ACTION_W-1:0]  r_action;
    logic [KEY_W-1:0]     r_key;

    // block state
    logic [CNT_W-1:0]     r_count;
    logic                 r_ticking;
    logic [KEY_COUNT-1:0] r_pressed;
    logic                 r_done;
    logic [FIRED_W-1:0]   r_fired;
    logic                 r_reject;

    // output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // control
    logic      w_accept;
    logic      w_reject;
    logic      w_match;
    logic      w_result_wr;
    t_cell_ctl w_ctl;

    logic [TIME_EXT_W-1:0] w_time_ext;
    logic [KEYMAP_W-1:0]   w_keys_ext;
    logic [KEY_COUNT-1:0]  w_key_dec;

    // cell row
    logic                 c_mark   [MAX_EVENTS];
    logic [TIME_BITS-1:0] c_time   [MAX_EVENTS];
    logic [ACTION_W-1:0]  c_action [MAX_EVENTS];
    logic [KEY_W-1:0]     c_key    [MAX_EVENTS];

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_reject = r_ticking || (r_count == CNT_W'(MAX_EVENTS));
    assign w_match  = (r_count != '0) && (c_time[0] == r_time);

    // Pick entry_time on a load, now_tick on a tick; keep the low TIME_BITS.
    assign w_time_ext = (s_axis_tuser == FUNC_TICK)
                      ? {{(TIME_EXT_W - IN_TIME_W){1'b0}}, s_axis_tdata[71:40]}
                      : {{(TIME_EXT_W - IN_TIME_W){1'b0}}, s_axis_tdata[31:0]};

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (s_axis_tuser == FUNC_TICK) ? ST_FIRE : ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_RESULT;
            end
            ST_FIRE: begin
                if (!w_match) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (w_result_wr) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------------
    always_comb begin
        s_axis_tready = 1'b0;
        w_ctl         = '0;
        w_result_wr   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_LOAD: begin
                w_ctl.load = !w_reject;
            end
            ST_FIRE: begin
                w_ctl.pop = w_match;
            end
            ST_RESULT: begin
                w_result_wr = !r_out_valid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Row of table cells; cell 0 is the head
    // ------------------------------------------------------------------------
    for (genvar gi = 0; gi < MAX_EVENTS; gi++) begin : g_cell
        logic                 w_lmark;
        logic [TIME_BITS-1:0] w_ltime,   w_rtime;
        logic [ACTION_W-1:0]  w_laction, w_raction;
        logic [KEY_W-1:0]     w_lkey,    w_rkey;

        if (gi == 0) begin : g_first
            assign w_lmark   = 1'b0;
            assign w_ltime   = r_time;
            assign w_laction = r_action;
            assign w_lkey    = r_key;
        end else begin : g_inner_l
            assign w_lmark   = c_mark[gi-1];
            assign w_ltime   = c_time[gi-1];
            assign w_laction = c_action[gi-1];
            assign w_lkey    = c_key[gi-1];
        end

        if (gi == MAX_EVENTS - 1) begin : g_last
            assign w_rtime   = c_time[gi];
            assign w_raction = c_action[gi];
            assign w_rkey    = c_key[gi];
        end else begin : g_inner_r
            assign w_rtime   = c_time[gi+1];
            assign w_raction = c_action[gi+1];
            assign w_rkey    = c_key[gi+1];
        end

        ter_cell #(
            .TIME_BITS (TIME_BITS),
            .CNT_W     (CNT_W),
            .INDEX     (gi)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_count        (r_count),
            .i_new_time     (r_time),
            .i_new_action   (r_action),
            .i_new_key      (r_key),
            .i_left_mark    (w_lmark),
            .i_left_time    (w_ltime),
            .i_left_action  (w_laction),
            .i_left_key     (w_lkey),
            .i_right_time   (w_rtime),
            .i_right_action (w_raction),
            .i_right_key    (w_rkey),
            .o_mark         (c_mark[gi]),
            .o_time         (c_time[gi]),
            .o_action       (c_action[gi]),
            .o_key          (c_key[gi])
        );
    end

    // Decode the head entry's key; keys at or beyond KEY_COUNT decode to none.
    always_comb begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            w_key_dec[k] = (c_key[0] == KEY_W'(k));
        end
    end

    always_comb begin
        w_keys_ext                = '0;
        w_keys_ext[KEY_COUNT-1:0] = r_pressed;
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ticking   <= 1'b0;
            r_pressed   <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_accept && (s_axis_tuser == FUNC_TICK)) begin
                r_ticking <= 1'b1;
            end

            // grow the table on a taken load, shrink it as the head fires
            if (w_ctl.load) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_ctl.pop) begin
                r_count <= r_count - CNT_W'(1);
            end

            // apply the firing head entry
            if (w_ctl.pop) begin
                if (c_action[0] == ACT_DISCONNECT) begin
                    r_done <= 1'b1;
                end else if (c_action[0] == ACT_PRESS) begin
                    r_pressed <= r_pressed | w_key_dec;
                end else if (c_action[0] == ACT_RELEASE) begin
                    r_pressed <= r_pressed & ~w_key_dec;
                end
            end

            if (w_result_wr) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_time   <= w_time_ext[TIME_BITS-1:0];
            r_action <= s_axis_tdata[33:32];
            r_key    <= s_axis_tdata[39:34];
            r_fired  <= '0;
            r_reject <= 1'b0;
        end else begin
            if (r_state == ST_LOAD) begin
                r_reject <= w_reject;
            end
            // count fired entries, hold at the top of the field
            if (w_ctl.pop && (r_fired != FIRED_MAX)) begin
                r_fired <= r_fired + FIRED_W'(1);
            end
        end

        if (w_result_wr) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, r_reject, r_fired, r_done, w_keys_ext};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_EVENTS))
        else $error("table fill count beyond capacity");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |-> (r_count != '0))
        else $error("head fired from an empty table");

    a_no_load_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load |-> !r_ticking)
        else $error("entry inserted after ticking began");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && w_reject) |=> $stable(r_count))
        else $error("refused load changed the table");

    a_fired_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.pop && r_fired != FIRED_MAX) |=> r_fired == $past(r_fired) + FIRED_W'(1))
        else $error("fired count did not advance");
`endif

endmodule

// File: dv/tb_timed_event_replay.sv
// ============================================================================
// tb_timed_event_replay - self-checking bench for the timed event replay block
// Loads a time-sorted table of key actions from a directed table and random
// entries until it overflows, then replays it with a long run of ticks. Each
// output transaction is checked field by field against its directed row or
// an in-bench predictor while both stream sides idle and stall at random.
// ============================================================================
module tb_timed_event_replay;
    timeunit 1ns;
    timeprecision 1ps;

    import ter_pkg::*;

    localparam int RESET_CYCLES     = 9;
    localparam int WATCHDOG_LIMIT   = 4000;  // quiet cycles before giving up
    localparam int DRAIN_CYCLES     = 80;    // covers a tick that fires a full table
    localparam int OVERFLOW_LOADS   = 4;
    localparam int TICK_PHASE_ITEMS = 1180;
    localparam int LONG_HOLD_AT     = 40;    // inputs accepted before the long hold
    localparam int LONG_HOLD_CYCLES = 300;

    // action code the block stores and fires but never acts on
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    // times compare in the low TIME_BITS bits only
    localparam int TIME_CMP_W = (TIME_BITS_DEF < IN_TIME_W) ? TIME_BITS_DEF : IN_TIME_W;
    localparam logic [IN_TIME_W-1:0] TIME_MASK = {IN_TIME_W{1'b1}} >> (IN_TIME_W - TIME_CMP_W);

    // one input transaction; the low fields follow the tdata layout
    typedef struct packed {
        logic                 func;
        logic [IN_TIME_W-1:0] now;
        logic [KEY_W-1:0]     key;
        logic [ACTION_W-1:0]  act;
        logic [IN_TIME_W-1:0] due;
    } replay_item_t;

    // one output transaction, in tdata order from the top down
    typedef struct packed {
        logic                rej;
        logic [FIRED_W-1:0]  fired;
        logic                fin;
        logic [KEYMAP_W-1:0] keys;
    } replay_result_t;

    typedef struct packed {
        replay_item_t   item;
        replay_result_t want;
    } load_row_t;

    // any accepted load before the first tick leaves every output field at zero
    localparam replay_result_t LOAD_OK = '0;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [31:0] entry_time, [33:32] entry_action, [39:34] entry_key,
    // [71:40] now_tick
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [0] func
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [63:0] keys_pressed, [64] finished, [71:65] fired_count,
    // [72] load_rejected, [79:73] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    timed_event_replay u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Replay predictor: a private copy of the sorted table and key state
    // ------------------------------------------------------------------
    logic [IN_TIME_W-1:0] sched_due [MAX_EVENTS_DEF];
    logic [ACTION_W-1:0]  sched_act [MAX_EVENTS_DEF];
    logic [KEY_W-1:0]     sched_key [MAX_EVENTS_DEF];
    int                   sched_fill = 0;
    int                   sched_head = 0;
    logic [KEYMAP_W-1:0]  held_keys = '0;
    logic                 disc_seen = 1'b0;
    logic                 tick_seen = 1'b0;

    replay_result_t pending_results [$];
    int             mismatch_count = 0;
    int             items_sent = 0;
    int             gap_draws = 0;
    bit             gapless = 1'b0;

    function automatic replay_result_t replay_predict(input replay_item_t it);
        replay_result_t       res;
        int                   pos;
        int                   fired;
        logic [IN_TIME_W-1:0] stamp;
        res   = '0;
        fired = 0;
        if (it.func == FUNC_LOAD) begin
            if (tick_seen || sched_fill >= MAX_EVENTS_DEF) begin
                // refuse: table full or replay already under way
                res.rej = 1'b1;
            end else begin
                // insert after every entry that is not later, keeping ties stable
                stamp = it.due & TIME_MASK;
                pos   = sched_fill;
                while (pos > 0 && sched_due[pos-1] > stamp) begin
                    sched_due[pos] = sched_due[pos-1];
                    sched_act[pos] = sched_act[pos-1];
                    sched_key[pos] = sched_key[pos-1];
                    pos--;
                end
                sched_due[pos] = stamp;
                sched_act[pos] = it.act;
                sched_key[pos] = it.key;
                sched_fill++;
            end
        end else begin
            stamp     = it.now & TIME_MASK;
            tick_seen = 1'b1;
            // fire from the head while times match exactly; a stale head blocks
            while (sched_head < sched_fill && sched_due[sched_head] == stamp) begin
                case (sched_act[sched_head])
                    ACT_DISCONNECT: disc_seen = 1'b1;
                    ACT_PRESS: begin
                        if (int'(sched_key[sched_head]) < KEY_COUNT_DEF)
                            held_keys[sched_key[sched_head]] = 1'b1;
                    end
                    ACT_RELEASE: begin
                        if (int'(sched_key[sched_head]) < KEY_COUNT_DEF)
                            held_keys[sched_key[sched_head]] = 1'b0;
                    end
                    default: ;
                endcase
                sched_head++;
                if (fired < int'(FIRED_MAX))
                    fired++;
            end
        end
        res.keys  = held_keys;
        res.fin   = disc_seen;
        res.fired = fired[FIRED_W-1:0];
        return res;
    endfunction

    function automatic replay_item_t mk_load(input logic [IN_TIME_W-1:0] due,
                                             input logic [ACTION_W-1:0] act,
                                             input logic [KEY_W-1:0] key);
        replay_item_t it;
        it      = '0;
        it.func = FUNC_LOAD;
        it.due  = due;
        it.act  = act;
        it.key  = key;
        return it;
    endfunction

    function automatic replay_item_t mk_tick(input logic [IN_TIME_W-1:0] now);
        replay_item_t it;
        it      = '0;
        it.func = FUNC_TICK;
        it.now  = now;
        return it;
    endfunction

    // cluster most times on a few ticks so that several entries share one
    function automatic replay_item_t rand_load();
        int                   r;
        logic [IN_TIME_W-1:0] due;
        logic [ACTION_W-1:0]  act;
        r = $urandom_range(0, 99);
        if (r < 60)
            due = $urandom_range(1, 12);
        else if (r < 85)
            due = $urandom;
        else
            due = $urandom_range(0, 3);
        r = $urandom_range(0, 9);
        if (r < 4)
            act = ACT_PRESS;
        else if (r < 8)
            act = ACT_RELEASE;
        else if (r == 8)
            act = ACT_DISCONNECT;
        else
            act = ACT_SPARE;
        return mk_load(due, act, KEY_W'($urandom_range(0, 63)));
    endfunction

    // mostly short gaps, a few long ones, and whole stretches with none
    function automatic int pick_gap();
        int r;
        gap_draws++;
        if (gap_draws % 64 == 0)
            gapless = ($urandom_range(0, 3) == 0);
        if (gapless)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one transaction after an optional gap; hold it until accepted.
    // tvalid stays high between back-to-back transactions.
    task automatic send_item(input replay_item_t it, input replay_result_t want,
                             input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.now, it.key, it.act, it.due};
        s_axis_tuser  <= it.func;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results = {pending_results, want};
        items_sent++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        load_row_t    rows [14];
        replay_item_t it;
        int           r;

        // Directed loads straight after reset. Cover both time extremes, key
        // 0 and 63, every action code including the inert one, ties at one
        // tick where the last entry for a key must win, and firing after a
        // disconnect.
        rows = '{
            '{mk_load(32'h0000_0000, ACT_PRESS,      6'd0),  LOAD_OK},
            '{mk_load(32'hFFFF_FFFF, ACT_DISCONNECT, 6'd63), LOAD_OK},
            '{mk_load(32'h0000_0005, ACT_PRESS,      6'd63), LOAD_OK},
            '{mk_load(32'h0000_0005, ACT_RELEASE,    6'd63), LOAD_OK},
            '{mk_load(32'h0000_0005, ACT_PRESS,      6'd0),  LOAD_OK},
            '{mk_load(32'h0000_0003, ACT_SPARE,      6'd21), LOAD_OK},
            '{mk_load(32'h0000_0003, ACT_PRESS,      6'd42), LOAD_OK},
            '{mk_load(32'h0000_0000, ACT_RELEASE,    6'd0),  LOAD_OK},
            '{mk_load(32'h0000_0000, ACT_PRESS,      6'd0),  LOAD_OK},
            '{mk_load(32'h8000_0000, ACT_PRESS,      6'd31), LOAD_OK},
            '{mk_load(32'h0000_0007, ACT_DISCONNECT, 6'd0),  LOAD_OK},
            '{mk_load(32'h0000_0007, ACT_PRESS,      6'd10), LOAD_OK},
            '{mk_load(32'hAAAA_AAAA, ACT_PRESS,      6'd42), LOAD_OK},
            '{mk_load(32'h5555_5555, ACT_RELEASE,    6'd21), LOAD_OK}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            // keep the predictor in step; the typed row is the expectation
            void'(replay_predict(rows[k].item));
            send_item(rows[k].item, rows[k].want, pick_gap());
        end

        // fill the table with random entries, then overflow it
        while (sched_fill < MAX_EVENTS_DEF) begin
            it = rand_load();
            send_item(it, replay_predict(it), pick_gap());
        end
        repeat (OVERFLOW_LOADS) begin
            it = rand_load();
            send_item(it, replay_predict(it), pick_gap());
        end

        // hold the sender until the whole load phase has drained
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);

        // Replay: aim most ticks at the head time so that groups fire, mix in
        // off-time ticks and loads that must now be refused.
        for (int n = 0; n < TICK_PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 12)
                it = rand_load();
            else if (r < 45 && sched_head < sched_fill)
                it = mk_tick(sched_due[sched_head]);
            else if (r < 80)
                it = mk_tick(IN_TIME_W'($urandom_range(0, 15)));
            else
                it = mk_tick($urandom);
            send_item(it, replay_predict(it), pick_gap());
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("timed_event_replay regression: pass");
        else
            $display("timed_event_replay regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, quiet windows, one long hold-off
    // ------------------------------------------------------------------
    initial begin
        int hold;
        int cyc;
        bit long_done;
        hold      = 0;
        cyc       = 0;
        long_done = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (!long_done && items_sent >= LONG_HOLD_AT) begin
                // hold off long enough for the block to fill and stall its input
                long_done = 1'b1;
                hold      = LONG_HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if ((cyc % 512) >= 128 && $urandom_range(0, 99) < 20) begin
                hold = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                                    : $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each output transaction with the oldest
    // expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        replay_result_t got;
        replay_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = replay_result_t'(m_axis_tdata[OUT_DATA_W-OUT_PAD_W-1:0]);
            if (m_axis_tdata[OUT_DATA_W-1 -: OUT_PAD_W] != '0) begin
                $error("pad bits: expected 0, got %0h",
                       m_axis_tdata[OUT_DATA_W-1 -: OUT_PAD_W]);
                mismatch_count++;
            end
            if (pending_results.size() == 0) begin
                $error("result with no expectation waiting: %0h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.keys !== want.keys) begin
                    $error("keys_pressed: expected %016h, got %016h", want.keys, got.keys);
                    mismatch_count++;
                end
                if (got.fin !== want.fin) begin
                    $error("finished: expected %0b, got %0b", want.fin, got.fin);
                    mismatch_count++;
                end
                if (got.fired !== want.fired) begin
                    $error("fired_count: expected %0d, got %0d", want.fired, got.fired);
                    mismatch_count++;
                end
                if (got.rej !== want.rej) begin
                    $error("load_rejected: expected %0b, got %0b", want.rej, got.rej);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no transaction moves for too long
    // ------------------------------------------------------------------
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timed_event_replay regression: fail");
        $finish;
    end

endmodule

// File: timed_event_replay.f
design/ter_pkg.sv
design/ter_cell.sv
design/timed_event_replay.sv
dv/tb_timed_event_replay.sv
